FILE: src/go_back_n_sender_window_unit_macros.svh
// Assertion macros for the go-back-n sender window unit.
// Both expect clk and rst in the scope of the use.
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_MACROS_SVH

// Same-cycle implication.
`define GBN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbn check failed");

// Next-cycle implication.
`define GBN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbn check failed");

`endif

FILE: src/gbn_pkg.sv
package gbn_pkg;

  localparam int MAX_WINDOW = 16;

  // opcodes of a request
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PKT   = 2'd1;
  localparam logic [1:0] OP_TMO   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [7:0] ACK_TYPE = 8'h32;
  localparam logic [3:0] TRY_MAX  = 4'd15;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_TOTAL  = 2'd1;
  localparam logic [1:0] REG_TRIES  = 2'd2;

  localparam logic [4:0]  WINDOW_RESET = 5'd1;
  localparam logic [15:0] TOTAL_RESET  = 16'd0;
  localparam logic [3:0]  TRIES_RESET  = 4'd5;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2,
    PH_FAIL = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DECIDE,
    CS_WINDOW,
    CS_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_WINDOW,
    ACT_FAIL
  } action_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic setup;
    logic emit;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    emit_end;
  } sts_t;

endpackage

FILE: src/gbn_ifs.sv
interface gbn_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] ack_number;
  logic [7:0]  packet_type;

  modport source (output valid, output opcode, output ack_number, output packet_type,
                  input ready);
  modport sink (input valid, input opcode, input ack_number, input packet_type,
                output ready);
endinterface

interface gbn_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] seq_number;
  logic        last;

  modport source (output valid, output kind, output seq_number, output last,
                  input ready);
  modport sink (input valid, input kind, input seq_number, input last,
                output ready);
endinterface

interface gbn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/go_back_n_sender_window_unit.sv
// A window or completion result is loaded into the output register after its request is accepted
// and passes decide and setup; a failure result skips setup; a request with no result ends after decide.
// One result per cycle during a burst while the receiver is ready; a window has at most MAX_WINDOW
// results, and the request channel stays closed until the final result of a window or failure is loaded.
// Reset (synchronous, rst high): phase idle, counters and window cleared, output empty,
// configuration back to window 1, total 0, tries 5.
module go_back_n_sender_window_unit #(
  parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW
) (
  input logic     clk,
  input logic     rst,
  gbn_req_if.sink req,
  gbn_res_if.source res,
  gbn_cfg_if.sink cfg
);

  gbn_pkg::cmd_t cmd;
  gbn_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  gbn_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbn_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_opcode      (req.opcode),
    .req_ack_number  (req.ack_number),
    .req_packet_type (req.packet_type),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .res_ready       (res.ready),
    .res_valid       (res.valid),
    .res_kind        (res.kind),
    .res_seq_number  (res.seq_number),
    .res_last        (res.last)
  );

endmodule

FILE: src/gbn_datapath.sv
module gbn_datapath #(
  parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW
) (
  input  logic            clk,
  input  logic            rst,
  input  gbn_pkg::cmd_t   cmd,
  output gbn_pkg::sts_t   sts,
  input  logic [1:0]      req_opcode,
  input  logic [15:0]     req_ack_number,
  input  logic [7:0]      req_packet_type,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            res_ready,
  output logic            res_valid,
  output logic [1:0]      res_kind,
  output logic [15:0]     res_seq_number,
  output logic            res_last
);

  logic [4:0]  win_size;
  logic [15:0] total_packets;
  logic [3:0]  try_limit;

  logic [1:0]  op;
  logic [15:0] ack;
  logic [7:0]  typ;

  logic [15:0]     last_acked;
  logic [15:0]     window_top;
  logic [3:0]      timeout_count;
  gbn_pkg::phase_t phase;
  logic [1:0]      kind;
  logic [15:0]     seq;

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [15:0] out_seq;
  logic        out_last;

  logic [15:0] ack_dec;
  logic [3:0]  tries_inc;
  logic        running;
  logic        advance;
  logic        tmo_hit;
  gbn_pkg::action_t action;

  logic [16:0] win_w;
  logic [16:0] win_sum;
  logic [15:0] win_top;
  logic        win_done;

  logic slot_free;
  logic load;
  logic is_data;
  logic emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size      <= gbn_pkg::WINDOW_RESET;
      total_packets <= gbn_pkg::TOTAL_RESET;
      try_limit     <= gbn_pkg::TRIES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        gbn_pkg::REG_WINDOW: win_size      <= cfg_data[4:0];
        gbn_pkg::REG_TOTAL:  total_packets <= cfg_data;
        gbn_pkg::REG_TRIES:  try_limit     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= req_opcode;
      ack <= req_ack_number;
      typ <= req_packet_type;
    end
  end

  // classify the held request
  assign ack_dec   = ack - 16'd1;
  assign tries_inc = (timeout_count == gbn_pkg::TRY_MAX) ? timeout_count
                                                        : timeout_count + 4'd1;
  assign running   = (phase == gbn_pkg::PH_RUN);

  always_comb begin
    action  = gbn_pkg::ACT_NONE;
    advance = 1'b0;
    tmo_hit = 1'b0;
    case (op)
      gbn_pkg::OP_START: action = gbn_pkg::ACT_WINDOW;
      gbn_pkg::OP_PKT: begin
        if (running && typ == gbn_pkg::ACK_TYPE && ack != 16'd0) begin
          if (ack_dec == last_acked) begin
            action = gbn_pkg::ACT_WINDOW;
          end else if (ack_dec > last_acked && ack_dec <= window_top) begin
            advance = 1'b1;
            if (ack_dec == window_top) action = gbn_pkg::ACT_WINDOW;
          end
        end
      end
      gbn_pkg::OP_TMO: begin
        if (running) begin
          tmo_hit = 1'b1;
          action  = (tries_inc < try_limit) ? gbn_pkg::ACT_WINDOW : gbn_pkg::ACT_FAIL;
        end
      end
      default: ;
    endcase
  end

  // window bounds; size 0 acts as 1, clamp to MAX_WINDOW
  always_comb begin
    win_w = {12'd0, win_size};
    if (win_size == 5'd0) win_w = 17'd1;
    else if (win_w > 17'(MAX_WINDOW)) win_w = 17'(MAX_WINDOW);
  end

  assign win_sum  = {1'b0, last_acked} + win_w;
  assign win_top  = (win_sum > {1'b0, total_packets}) ? total_packets : win_sum[15:0];
  assign win_done = (last_acked >= total_packets);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_acked    <= '0;
      window_top    <= '0;
      timeout_count <= '0;
      phase         <= gbn_pkg::PH_IDLE;
      kind          <= gbn_pkg::KIND_DATA;
      seq           <= '0;
    end else begin
      if (cmd.decide) begin
        if (op == gbn_pkg::OP_START) last_acked <= '0;
        else if (advance) last_acked <= ack_dec;
        if (tmo_hit) timeout_count <= tries_inc;
        if (action == gbn_pkg::ACT_FAIL) begin
          phase <= gbn_pkg::PH_FAIL;
          kind  <= gbn_pkg::KIND_FAIL;
        end
      end
      if (cmd.setup) begin
        if (win_done) begin
          phase      <= gbn_pkg::PH_DONE;
          window_top <= last_acked;
          kind       <= gbn_pkg::KIND_DONE;
        end else begin
          phase      <= gbn_pkg::PH_RUN;
          window_top <= win_top;
          seq        <= last_acked + 16'd1;
          kind       <= gbn_pkg::KIND_DATA;
        end
      end
      if (load) seq <= seq + 16'd1;
    end
  end

  // output register: load when empty or being drained
  assign slot_free = !out_valid || res_ready;
  assign load      = cmd.emit && slot_free;
  assign is_data   = (kind == gbn_pkg::KIND_DATA);
  assign emit_last = !is_data || (seq == window_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= kind;
      out_seq  <= is_data ? seq : 16'd0;
      out_last <= emit_last;
    end
  end

  assign sts.action   = action;
  assign sts.emit_end = load && emit_last;

  assign res_valid      = out_valid;
  assign res_kind       = out_kind;
  assign res_seq_number = out_seq;
  assign res_last       = out_last;

endmodule

FILE: src/gbn_controller.sv
module gbn_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  gbn_pkg::sts_t sts,
  output gbn_pkg::cmd_t cmd
);

  gbn_pkg::ctrl_state_t state;
  gbn_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbn_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      gbn_pkg::CS_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) state_next = gbn_pkg::CS_DECIDE;
      end
      gbn_pkg::CS_DECIDE: begin
        cmd.decide = 1'b1;
        case (sts.action)
          gbn_pkg::ACT_WINDOW: state_next = gbn_pkg::CS_WINDOW;
          gbn_pkg::ACT_FAIL:   state_next = gbn_pkg::CS_EMIT;
          default:             state_next = gbn_pkg::CS_IDLE;
        endcase
      end
      gbn_pkg::CS_WINDOW: begin
        cmd.setup  = 1'b1;
        state_next = gbn_pkg::CS_EMIT;
      end
      gbn_pkg::CS_EMIT: begin
        cmd.emit = 1'b1;
        // hold until the final result of the burst is loaded
        if (sts.emit_end) state_next = gbn_pkg::CS_IDLE;
      end
      default: state_next = gbn_pkg::CS_IDLE;
    endcase
  end

endmodule

FILE: src/gbn_checker.sv
`include "go_back_n_sender_window_unit_macros.svh"

module gbn_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_kind,
  input logic [15:0] res_seq_number,
  input logic        res_last
);

  // a stalled result holds
  `GBN_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_seq_number) && $stable(res_last))

  // completion and failure are single results with no sequence number
  `GBN_ASSERT_NOW(a_status_single, res_valid && res_kind != gbn_pkg::KIND_DATA, res_last && res_seq_number == 16'd0)

  // one request at a time: the channel closes after each accept
  `GBN_ASSERT_NEXT(a_req_one, req_valid && req_ready, !req_ready)

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_kind       (res.kind),
  .res_seq_number (res.seq_number),
  .res_last       (res.last)
);

FILE: tb/sv/go_back_n_sender_window_unit_tb.sv
module go_back_n_sender_window_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 500;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq_number;
    logic        last;
  } send_t;

  logic clk;
  logic rst;

  gbn_req_if req_bus();
  gbn_res_if res_bus();
  gbn_cfg_if cfg_bus();

  go_back_n_sender_window_unit i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .res(res_bus),
    .cfg(cfg_bus)
  );

  // sender state as the block should hold it
  logic [4:0]  cfg_window;
  logic [15:0] cfg_total;
  logic [3:0]  cfg_tries;
  logic [15:0] acked;
  logic [15:0] win_top;
  logic [3:0]  tmo_count;
  phase_t      ph;

  send_t expected_sends[$];
  int    mismatches;
  int    sent_count;
  bit    idle_on;
  int    quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Queue the current window, or completion when nothing is left to send.
  function automatic void queue_window_send();
    int w;
    int top;
    int s;
    w = int'(cfg_window);
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    if (acked >= cfg_total) begin
      ph = PH_DONE;
      win_top = acked;
      expected_sends.push_back({KIND_DONE, 16'd0, 1'b1});
      return;
    end
    top = int'(acked) + w;
    if (top > int'(cfg_total)) top = int'(cfg_total);
    win_top = 16'(top);
    ph = PH_RUN;
    for (s = int'(acked) + 1; s <= top; s++)
      expected_sends.push_back({KIND_DATA, 16'(s), s == top});
  endfunction

  // Apply one request to the expected sender state.
  function automatic void predict_sender_step(logic [1:0] op, logic [15:0] ack,
                                              logic [7:0] typ);
    logic [15:0] a;
    if (op == OP_START) begin
      acked = 16'd0;
      queue_window_send();
      return;
    end
    if (ph != PH_RUN) return;
    if (op == OP_PKT) begin
      if (typ != ACK_TYPE || ack == 16'd0) return;
      a = ack - 16'd1;
      if (a == acked) begin
        queue_window_send();
      end else if (a > acked && a <= win_top) begin
        acked = a;
        if (acked == win_top) queue_window_send();
      end
    end else if (op == OP_TMO) begin
      if (tmo_count < TRY_MAX) tmo_count++;
      if (tmo_count < cfg_tries) queue_window_send();
      else begin
        ph = PH_FAIL;
        expected_sends.push_back({KIND_FAIL, 16'd0, 1'b1});
      end
    end
  endfunction

  // Hold the request channel idle until every result is in and the block has settled.
  task automatic drain_results();
    req_bus.valid = 1'b0;
    while (expected_sends.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    drain_results();
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_WINDOW: cfg_window = data[4:0];
      REG_TOTAL:  cfg_total  = data;
      REG_TRIES:  cfg_tries  = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Enter and leave at a falling edge; valid stays high for a back-to-back request.
  task automatic send_request(input logic [1:0] op, input logic [15:0] ack,
                              input logic [7:0] typ);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid       = 1'b1;
    req_bus.opcode      = op;
    req_bus.ack_number  = ack;
    req_bus.packet_type = typ;
    do @(posedge clk); while (!req_bus.ready);
    predict_sender_step(op, ack, typ);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic test_idle_requests();
    send_request(OP_PKT, 16'd1, ACK_TYPE);
    send_request(OP_TMO, 16'hFFFF, 8'hFF);
    send_request(OP_NONE, 16'h5A5A, ACK_TYPE);
    // total 0 completes at once
    send_request(OP_START, 16'd0, 8'h00);
  endtask

  task automatic test_stop_and_wait();
    write_register(REG_WINDOW, 16'd0);
    write_register(REG_TOTAL, 16'd3);
    write_register(REG_TRIES, 16'd15);
    send_request(OP_START, 16'd0, 8'h00);
    send_request(OP_PKT, 16'd2, ACK_TYPE);
    send_request(OP_PKT, 16'd2, ACK_TYPE);
    send_request(OP_TMO, 16'd0, 8'h00);
    send_request(OP_PKT, 16'd3, ACK_TYPE);
    send_request(OP_PKT, 16'd4, ACK_TYPE);
    send_request(OP_PKT, 16'd5, ACK_TYPE);
  endtask

  task automatic test_wide_window();
    write_register(REG_WINDOW, 16'hFFFF);
    write_register(REG_TOTAL, 16'hFFFF);
    send_request(OP_START, 16'd0, 8'h00);
    send_request(OP_PKT, 16'd0, ACK_TYPE);
    send_request(OP_PKT, 16'hFFFF, ACK_TYPE);
    send_request(OP_PKT, 16'd5, 8'hCD);
    send_request(OP_PKT, 16'd9, ACK_TYPE);
    send_request(OP_PKT, 16'd17, ACK_TYPE);
    write_register(REG_WINDOW, 16'd17);
    send_request(OP_START, 16'd0, 8'h00);
  endtask

  task automatic test_give_up();
    write_register(REG_TRIES, 16'd0);
    send_request(OP_TMO, 16'd0, 8'h00);
    send_request(OP_TMO, 16'd0, 8'h00);
    send_request(OP_START, 16'd0, 8'h00);
    write_register(REG_TRIES, 16'd1);
    send_request(OP_TMO, 16'd0, 8'h00);
    write_register(REG_UNUSED, 16'hFFFF);
  endtask

  task automatic random_config();
    logic [4:0]  w;
    logic [15:0] t;
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: w = 5'd0;
      1: w = 5'd1;
      2: w = 5'd16;
      3: w = 5'd17 + 5'($urandom_range(0, 14));
      default: w = 5'($urandom_range(1, 16));
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: t = 16'd0;
      1: t = 16'hFFFF;
      2: t = 16'($urandom);
      default: t = 16'($urandom_range(1, 40));
    endcase
    write_register(REG_WINDOW, {11'($urandom), w});
    write_register(REG_TOTAL, t);
    write_register(REG_TRIES, {12'($urandom), 4'($urandom_range(0, 15))});
  endtask

  task automatic test_random_traffic();
    int phase_end;
    int pick;
    logic [1:0]  op;
    logic [15:0] ack;
    logic [7:0]  typ;
    while (sent_count < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      random_config();
      phase_end = sent_count + int'($urandom_range(30, 70));
      while (sent_count < phase_end && sent_count < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        op   = OP_PKT;
        typ  = ACK_TYPE;
        ack  = acked + 16'd1;
        if (ph != PH_RUN && pick < 70) begin
          op = OP_START;
          ack = 16'($urandom);
          typ = 8'($urandom);
        end else if (ph == PH_RUN && pick < 60 && win_top > acked) begin
          ack = acked + 16'd1 + 16'($urandom_range(1, int'(win_top - acked)));
        end else if (ph == PH_RUN && pick < 70) begin
          ack = acked + 16'd1;
        end else if (ph == PH_RUN && pick < 75) begin
          op = OP_TMO;
        end else if (ph == PH_RUN && pick < 80) begin
          op = OP_START;
        end else begin
          // noise: ignored opcode, foreign type, ack zero, random ack, ack out of window
          case ($urandom_range(0, 4))
            0: begin
              op = OP_NONE;
              ack = 16'($urandom);
              typ = 8'($urandom);
            end
            1: begin
              typ = 8'($urandom);
              ack = 16'($urandom);
            end
            2: ack = 16'd0;
            3: ack = 16'($urandom);
            default: ack = win_top + 16'd2 + 16'($urandom_range(0, 100));
          endcase
        end
        send_request(op, ack, typ);
      end
    end
  endtask

  // Receiver: while idle_on is set, stall a random number of cycles before each result.
  initial begin
    int stall;
    res_bus.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        res_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_bus.ready = 1'b1;
      do @(posedge clk); while (!res_bus.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    send_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_sends.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: kind %0d seq %0d last %0d",
                   res_bus.kind, res_bus.seq_number, res_bus.last);
      end else begin
        want = expected_sends.pop_front();
        if (res_bus.kind !== want.kind || res_bus.seq_number !== want.seq_number ||
            res_bus.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result differs: expected kind %0d seq %0d last %0d, got %0d %0d %0d",
                     want.kind, want.seq_number, want.last,
                     res_bus.kind, res_bus.seq_number, res_bus.last);
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("go_back_n_sender_window_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    req_bus.valid       = 1'b0;
    req_bus.opcode      = OP_START;
    req_bus.ack_number  = 16'd0;
    req_bus.packet_type = 8'd0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_WINDOW;
    cfg_bus.data        = 16'd0;
    cfg_window          = WINDOW_RESET;
    cfg_total           = TOTAL_RESET;
    cfg_tries           = TRIES_RESET;
    acked               = 16'd0;
    win_top             = 16'd0;
    tmo_count           = 4'd0;
    ph                  = PH_IDLE;
    mismatches          = 0;
    sent_count          = 0;
    idle_on             = 1'b1;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_idle_requests();
    test_stop_and_wait();
    test_wide_window();
    test_give_up();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_sends.size() == 0)
      $display("go_back_n_sender_window_unit: match");
    else
      $display("go_back_n_sender_window_unit: mismatch");
    $finish;
  end

endmodule
